### design/asrl_pkg.sv
// ----------------------------------------------------------------------------
// asrl_pkg
// Shared constants, codes and types for the stutter looper.
// ----------------------------------------------------------------------------
package asrl_pkg;

  localparam int MAX_FRAMES  = 16384;
  localparam int SAMPLE_BITS = 16;
  localparam int CHANNELS    = 2;

  localparam int BUF_W      = 15;
  localparam int START_W    = 14;
  localparam int END_W      = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  localparam logic [BUF_W-1:0]   BUF_RESET   = 15'd16384;
  localparam logic [START_W-1:0] START_RESET = 14'd0;
  localparam logic [END_W-1:0]   END_RESET   = 15'd16384;

  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_FRAMES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_START  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_END    = 2'd2;

  localparam logic [1:0] KIND_TICK       = 2'd0;
  localparam logic [1:0] KIND_ACTIVATE   = 2'd1;
  localparam logic [1:0] KIND_DEACTIVATE = 2'd2;

  localparam logic [1:0] MODE_PASS = 2'd0;
  localparam logic [1:0] MODE_REC  = 2'd1;
  localparam logic [1:0] MODE_REP  = 2'd2;

  // per-item info handed from control to the output stage
  typedef struct packed {
    logic       mem_sel;
    logic [1:0] mode;
  } tick_info_t;

  // store access request
  typedef struct packed {
    logic wr;
    logic rd;
  } mem_req_t;

endpackage

### design/audio_sample_repeat_looper_core.sv
// ----------------------------------------------------------------------------
// audio_sample_repeat_looper_core
// Stereo stutter looper: pass-through, record into the frame store, repeat.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i/in_ready_o  | kind, sample_left, sample_right
//  out     | output    | out_valid_o/out_ready_i| out_left, out_right, mode_now
//  cfg     | input     | cfg_valid_i/cfg_ready_o| cfg_index, cfg_data
//
// One item per cycle while in_ready_o is high. A frame tick is taken into the
// middle stage (store read at that edge), then into the output register;
// commands give no result.
// Reset clears mode, play head, config registers and valids; the store is not cleared.
// A stalled output holds the middle stage; input ready drops only when the
// middle stage and the output register are both full and out_ready_i is low.
module audio_sample_repeat_looper_core #(
  parameter int MaxFrames  = asrl_pkg::MAX_FRAMES,
  parameter int SampleBits = asrl_pkg::SAMPLE_BITS,
  parameter int Channels   = asrl_pkg::CHANNELS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [asrl_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [asrl_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          kind_i,
  input  logic signed [SampleBits-1:0]        sample_left_i,
  input  logic signed [SampleBits-1:0]        sample_right_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [SampleBits-1:0]        out_left_o,
  output logic signed [SampleBits-1:0]        out_right_o,
  output logic [1:0]                          mode_now_o
);
  import asrl_pkg::*;

  localparam int AddrW = $clog2(MaxFrames);

  logic                  accept, tick;
  tick_info_t            info;
  mem_req_t              req;
  logic [AddrW-1:0]      addr;
  logic signed [SampleBits-1:0] rd_left, rd_right, pass_right;

  logic                  b_valid_q;
  tick_info_t            b_info_q;
  logic signed [SampleBits-1:0] b_left_q, b_right_q;
  logic                  b_adv;

  logic                  o_valid_q;
  logic signed [SampleBits-1:0] o_left_q, o_right_q;
  logic [1:0]            o_mode_q;

  assign cfg_ready_o = 1'b1;
  assign b_adv       = !o_valid_q || out_ready_i;
  assign in_ready_o  = !b_valid_q || b_adv;
  assign accept      = in_valid_i && in_ready_o;

  asrl_ctrl #(
    .MaxFrames (MaxFrames),
    .AddrW     (AddrW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .kind_i      (kind_i),
    .tick_o      (tick),
    .info_o      (info),
    .req_o       (req),
    .addr_o      (addr)
  );

  asrl_store #(
    .Depth      (MaxFrames),
    .SampleBits (SampleBits),
    .Channels   (Channels),
    .AddrW      (AddrW)
  ) u_store (
    .clk_i      (clk_i),
    .req_i      (req),
    .addr_i     (addr),
    .wr_left_i  (sample_left_i),
    .wr_right_i (sample_right_i),
    .rd_left_o  (rd_left),
    .rd_right_o (rd_right)
  );

  // mono recording echoes left on both sides
  assign pass_right = (Channels == 1 && info.mode == MODE_REC) ? sample_left_i
                                                               : sample_right_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      b_valid_q <= tick;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && tick) begin
      b_info_q  <= info;
      b_left_q  <= sample_left_i;
      b_right_q <= pass_right;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (b_adv) begin
      o_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_adv && b_valid_q) begin
      o_left_q  <= b_info_q.mem_sel ? rd_left  : b_left_q;
      o_right_q <= b_info_q.mem_sel ? rd_right : b_right_q;
      o_mode_q  <= b_info_q.mode;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_left_o  = o_left_q;
  assign out_right_o = o_right_q;
  assign mode_now_o  = o_mode_q;

endmodule

### design/asrl_store.sv
// ----------------------------------------------------------------------------
// asrl_store
// Frame store: one write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module asrl_store #(
  parameter int Depth      = asrl_pkg::MAX_FRAMES,
  parameter int SampleBits = asrl_pkg::SAMPLE_BITS,
  parameter int Channels   = asrl_pkg::CHANNELS,
  parameter int AddrW      = $clog2(Depth)
) (
  input  logic                         clk_i,
  input  asrl_pkg::mem_req_t           req_i,
  input  logic [AddrW-1:0]             addr_i,
  input  logic signed [SampleBits-1:0] wr_left_i,
  input  logic signed [SampleBits-1:0] wr_right_i,
  output logic signed [SampleBits-1:0] rd_left_o,
  output logic signed [SampleBits-1:0] rd_right_o
);
  import asrl_pkg::*;

  localparam int StoreW = SampleBits * Channels;

  logic [StoreW-1:0] mem [Depth];
  logic [StoreW-1:0] wdata;
  logic [StoreW-1:0] rdata_q;

  generate
    if (Channels > 1) begin : g_stereo
      assign wdata = {wr_right_i, wr_left_i};
    end else begin : g_mono
      assign wdata = wr_left_i;
    end
  endgenerate

  always_ff @(posedge clk_i) begin
    if (req_i.wr) begin
      mem[addr_i] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd) begin
      rdata_q <= mem[addr_i];
    end
  end

  // mono: right slot is the left slot
  assign rd_left_o  = rdata_q[SampleBits-1:0];
  assign rd_right_o = rdata_q[StoreW-1 -: SampleBits];

endmodule

### design/asrl_ctrl.sv
// ----------------------------------------------------------------------------
// asrl_ctrl
// Config registers, mode and play head; issues store accesses per item.
// ----------------------------------------------------------------------------
module asrl_ctrl #(
  parameter int MaxFrames = asrl_pkg::MAX_FRAMES,
  parameter int AddrW     = $clog2(MaxFrames)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [asrl_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [asrl_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                               accept_i,
  input  logic [1:0]                         kind_i,
  output logic                               tick_o,
  output asrl_pkg::tick_info_t               info_o,
  output asrl_pkg::mem_req_t                 req_o,
  output logic [AddrW-1:0]                   addr_o
);
  import asrl_pkg::*;

  localparam int HeadW = $clog2(MaxFrames + 1);
  localparam int CmpW  = (HeadW > BUF_W) ? HeadW : BUF_W;

  logic [BUF_W-1:0]   buf_q;
  logic [START_W-1:0] start_q;
  logic [END_W-1:0]   end_q;
  logic [1:0]         mode_q, mode_d;
  logic [HeadW-1:0]   head_q, head_d;

  logic [CmpW-1:0] eff_buf, eff_end, eff_start, head_x, rd_idx, next_head;
  logic            mem_sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q   <= BUF_RESET;
      start_q <= START_RESET;
      end_q   <= END_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_BUFFER_FRAMES: buf_q   <= cfg_data_i[BUF_W-1:0];
        REG_REPEAT_START:  start_q <= cfg_data_i[START_W-1:0];
        REG_REPEAT_END:    end_q   <= cfg_data_i[END_W-1:0];
        default: ;
      endcase
    end
  end

  // section bounds, saturated
  always_comb begin
    eff_buf = CmpW'(buf_q);
    if (eff_buf == '0) eff_buf = CmpW'(1);
    if (eff_buf > CmpW'(MaxFrames)) eff_buf = CmpW'(MaxFrames);
    eff_end = CmpW'(end_q);
    if (eff_end == '0) eff_end = CmpW'(1);
    if (eff_end > eff_buf) eff_end = eff_buf;
    eff_start = CmpW'(start_q);
    if (eff_start > eff_end - CmpW'(1)) eff_start = eff_end - CmpW'(1);
  end

  assign head_x = CmpW'(head_q);

  always_comb begin
    mode_d  = mode_q;
    head_d  = head_q;
    req_o   = '0;
    rd_idx  = head_x;
    mem_sel = 1'b0;
    tick_o  = 1'b0;
    if (accept_i) begin
      unique case (kind_i)
        KIND_ACTIVATE: begin
          head_d = '0;
          mode_d = MODE_REC;
        end
        KIND_DEACTIVATE: begin
          mode_d = MODE_PASS;
        end
        KIND_TICK: begin
          tick_o = 1'b1;
          unique case (mode_q)
            MODE_REC: begin
              if (head_x >= eff_buf) begin
                rd_idx  = eff_start;
                req_o.rd = 1'b1;
                mem_sel = 1'b1;
                mode_d  = MODE_REP;
              end else begin
                req_o.wr = 1'b1;
              end
              head_d = next_head[HeadW-1:0];
            end
            MODE_REP: begin
              if (head_x >= eff_end) rd_idx = eff_start;
              req_o.rd = 1'b1;
              mem_sel  = 1'b1;
              head_d   = next_head[HeadW-1:0];
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  assign next_head    = rd_idx + CmpW'(1);
  assign addr_o       = rd_idx[AddrW-1:0];
  assign info_o.mem_sel = mem_sel;
  assign info_o.mode    = mode_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_PASS;
      head_q <= '0;
    end else begin
      mode_q <= mode_d;
      head_q <= head_d;
    end
  end

endmodule

### sim/audio_sample_repeat_looper_core_test.sv
// ----------------------------------------------------------------------------
// audio_sample_repeat_looper_core_test
// Self-checking bench for the stereo stutter looper. A behavioral copy of the
// looper (mode, play head, bounds, frame store) predicts every output frame.
// Covered: pass-through extremes, record/repeat, restart, bound saturation,
// reconfiguration while repeating, random sessions with stalls on both
// sides, and one long recording run back to back.
// ----------------------------------------------------------------------------
module audio_sample_repeat_looper_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import asrl_pkg::*;

  localparam int CLK_PERIOD   = 4;
  localparam int RESET_CYCLES = 10;
  localparam int IDLE_GAP     = 8;
  localparam int RANDOM_ITEMS = 1250;
  localparam int LONG_FRAMES  = 200;
  localparam int CYCLE_LIMIT  = 1000000;

  localparam logic [1:0]           KIND_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] left;
    logic [SAMPLE_BITS-1:0] right;
    logic [1:0]             mode;
  } looper_frame_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [CFG_IDX_W-1:0]          cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]         cfg_data_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  logic [1:0]                    kind_i = KIND_TICK;
  logic signed [SAMPLE_BITS-1:0] sample_left_i = '0;
  logic signed [SAMPLE_BITS-1:0] sample_right_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic signed [SAMPLE_BITS-1:0] out_left_o;
  logic signed [SAMPLE_BITS-1:0] out_right_o;
  logic [1:0]                    mode_now_o;

  audio_sample_repeat_looper_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .sample_left_i  (sample_left_i),
    .sample_right_i (sample_right_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_left_o     (out_left_o),
    .out_right_o    (out_right_o),
    .mode_now_o     (mode_now_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // looper state as the bench sees it
  logic [1:0]                 lp_mode = MODE_PASS;
  int unsigned                lp_head = 0;
  logic [BUF_W-1:0]           reg_buf = BUF_RESET;
  logic [START_W-1:0]         reg_start = START_RESET;
  logic [END_W-1:0]           reg_end = END_RESET;
  logic [2*SAMPLE_BITS-1:0]   frame_mem [MAX_FRAMES];
  bit                         frame_valid [MAX_FRAMES];
  looper_frame_t              frames_due [$];

  int          err_cnt = 0;
  int          items_sent = 0;
  int unsigned cycle_cnt = 0;
  bit          idle_on = 1'b1;
  int          in_gap_pct = 10;
  int          out_stall_pct = 10;
  int          stall_left = 0;
  int          pct_choice [3] = '{0, 10, 35};

  function automatic int unsigned rec_len();
    int unsigned b;
    b = 32'(reg_buf);
    if (b < 1) b = 1;
    if (b > MAX_FRAMES) b = MAX_FRAMES;
    return b;
  endfunction

  function automatic int unsigned wrap_end();
    int unsigned e;
    e = 32'(reg_end);
    if (e < 1) e = 1;
    if (e > rec_len()) e = rec_len();
    return e;
  endfunction

  function automatic int unsigned wrap_start();
    int unsigned s;
    s = 32'(reg_start);
    if (s > wrap_end() - 1) s = wrap_end() - 1;
    return s;
  endfunction

  // true if a tick right now would play a frame never recorded since reset
  function automatic bit tick_hits_blank();
    int unsigned slot;
    slot = lp_head;
    if (lp_mode == MODE_REC) begin
      if (lp_head < rec_len()) return 1'b0;
      slot = wrap_start();
    end else if (lp_mode == MODE_REP) begin
      if (lp_head >= wrap_end()) slot = wrap_start();
    end else begin
      return 1'b0;
    end
    return !frame_valid[slot];
  endfunction

  function automatic void advance_looper(input logic [1:0] kind,
                                         input logic [SAMPLE_BITS-1:0] left,
                                         input logic [SAMPLE_BITS-1:0] right);
    looper_frame_t f;
    case (kind)
      KIND_ACTIVATE: begin
        lp_head = 0;
        lp_mode = MODE_REC;
      end
      KIND_DEACTIVATE: lp_mode = MODE_PASS;
      KIND_TICK: begin
        if (lp_mode == MODE_PASS) begin
          f.left  = left;
          f.right = right;
        end else begin
          if (lp_mode == MODE_REC) begin
            if (lp_head >= rec_len()) begin
              lp_head = wrap_start();
              lp_mode = MODE_REP;
            end else begin
              frame_mem[lp_head]   = {(CHANNELS > 1) ? right : left, left};
              frame_valid[lp_head] = 1'b1;
            end
          end else if (lp_head >= wrap_end()) begin
            lp_head = wrap_start();
          end
          f.left  = frame_mem[lp_head][SAMPLE_BITS-1:0];
          f.right = frame_mem[lp_head][2*SAMPLE_BITS-1:SAMPLE_BITS];
          lp_head++;
        end
        f.mode = lp_mode;
        frames_due.push_back(f);
      end
      default: ;
    endcase
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] rand_sample();
    return SAMPLE_BITS'($urandom_range(2**SAMPLE_BITS - 1));
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic send_item(input logic [1:0] kind,
                           input logic [SAMPLE_BITS-1:0] left,
                           input logic [SAMPLE_BITS-1:0] right);
    if (idle_on && $urandom_range(99) < in_gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= kind;
    sample_left_i  <= left;
    sample_right_i <= right;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    advance_looper(kind, left, right);
    if (kind != KIND_UNUSED) items_sent++;
  endtask

  // a tick that would play an unrecorded frame becomes a restart instead
  task automatic send_tick(input logic [SAMPLE_BITS-1:0] left,
                           input logic [SAMPLE_BITS-1:0] right);
    if (tick_hits_blank()) send_item(KIND_ACTIVATE, left, right);
    else send_item(KIND_TICK, left, right);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk_i);
    repeat (IDLE_GAP) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_BUFFER_FRAMES: reg_buf = data[BUF_W-1:0];
      REG_REPEAT_START:  reg_start = data[START_W-1:0];
      REG_REPEAT_END:    reg_end = data[END_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input int b, input int s, input int e, input bit poke_unused);
    wait_idle();
    write_reg(REG_BUFFER_FRAMES, b[CFG_DATA_W-1:0]);
    write_reg(REG_REPEAT_START, s[CFG_DATA_W-1:0]);
    write_reg(REG_REPEAT_END, e[CFG_DATA_W-1:0]);
    if (poke_unused) write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(2**CFG_DATA_W - 1)));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_config();
    int b;
    int s;
    int e;
    int span;
    case ($urandom_range(7))
      0: b = 0;
      1: b = 2**CFG_DATA_W - 1;
      2: b = MAX_FRAMES;
      default: b = $urandom_range(1, 24);
    endcase
    span = (b > 0 && b < 30) ? b : 30;
    case ($urandom_range(7))
      0: s = 2**CFG_DATA_W - 1;
      1: s = 0;
      default: s = $urandom_range(0, span);
    endcase
    case ($urandom_range(7))
      0: e = 0;
      1: e = 2**CFG_DATA_W - 1;
      default: e = $urandom_range(1, span + 2);
    endcase
    configure(b, s, e, $urandom_range(7) == 0);
  endtask

  task automatic test_passthrough();
    send_item(KIND_TICK, 16'h8000, 16'h7fff);
    send_item(KIND_TICK, 16'h7fff, 16'h8000);
    send_item(KIND_TICK, 16'h0000, 16'hffff);
    send_item(KIND_UNUSED, 16'h1234, 16'h5678);
    send_item(KIND_DEACTIVATE, 16'hffff, 16'h0000);
    send_item(KIND_TICK, 16'hffff, 16'h0000);
  endtask

  task automatic test_record_and_repeat();
    configure(5, 2, 4, 1'b1);
    send_item(KIND_ACTIVATE, rand_sample(), rand_sample());
    repeat (9) send_tick(rand_sample(), rand_sample());
    // new bounds while repeating
    configure(5, 0, 5, 1'b0);
    repeat (2) send_tick(rand_sample(), rand_sample());
    // restart while active
    send_item(KIND_ACTIVATE, rand_sample(), rand_sample());
    repeat (2) send_tick(rand_sample(), rand_sample());
    send_item(KIND_DEACTIVATE, rand_sample(), rand_sample());
    send_tick(rand_sample(), rand_sample());
  endtask

  task automatic test_bound_saturation();
    // zero length, start past end, zero end: one frame loops
    configure(0, 2**CFG_DATA_W - 1, 0, 1'b0);
    send_item(KIND_ACTIVATE, rand_sample(), rand_sample());
    repeat (3) send_tick(rand_sample(), rand_sample());
  endtask

  task automatic test_random_sessions();
    int target;
    int n;
    logic [1:0] kind;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      in_gap_pct    = pct_choice[$urandom_range(2)];
      out_stall_pct = pct_choice[$urandom_range(2)];
      if ($urandom_range(5) == 0) random_config();
      if ($urandom_range(9) < 7) begin
        send_item(KIND_ACTIVATE, rand_sample(), rand_sample());
        n = $urandom_range(1, 2 * rec_len() + 12);
        if (n > 60) n = 60;
        repeat (n) send_tick(rand_sample(), rand_sample());
        if ($urandom_range(1)) send_item(KIND_DEACTIVATE, rand_sample(), rand_sample());
        repeat ($urandom_range(0, 4)) send_tick(rand_sample(), rand_sample());
      end else begin
        repeat ($urandom_range(1, 8)) begin
          kind = 2'($urandom_range(3));
          if (kind == KIND_TICK) send_tick(rand_sample(), rand_sample());
          else send_item(kind, rand_sample(), rand_sample());
        end
      end
    end
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    // end far past the length saturates to the length
    configure(LONG_FRAMES, LONG_FRAMES - 10, 2**CFG_DATA_W - 1, 1'b0);
    send_item(KIND_ACTIVATE, rand_sample(), rand_sample());
    repeat (LONG_FRAMES + 15) send_tick(rand_sample(), rand_sample());
    configure(LONG_FRAMES, 0, 3, 1'b0);
    repeat (5) send_tick(rand_sample(), rand_sample());
    configure(20, 18, 17000, 1'b0);
    repeat (5) send_tick(rand_sample(), rand_sample());
    send_item(KIND_DEACTIVATE, rand_sample(), rand_sample());
    repeat (3) send_tick(rand_sample(), rand_sample());
  endtask

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (idle_on && $urandom_range(99) < out_stall_pct) begin
      stall_left = $urandom_range(1, 18) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    looper_frame_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (frames_due.size() == 0) begin
        report_mismatch("output item with nothing expected");
      end else begin
        want = frames_due.pop_front();
        if (out_left_o !== want.left)
          report_mismatch($sformatf("out_left got %h want %h", out_left_o, want.left));
        if (out_right_o !== want.right)
          report_mismatch($sformatf("out_right got %h want %h", out_right_o, want.right));
        if (mode_now_o !== want.mode)
          report_mismatch($sformatf("mode_now got %0d want %0d", mode_now_o, want.mode));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items pending", cycle_cnt, frames_due.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_passthrough();
    test_record_and_repeat();
    test_bound_saturation();
    test_random_sessions();
    test_back_to_back();
    wait_idle();
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
design/asrl_pkg.sv
design/asrl_store.sv
design/asrl_ctrl.sv
design/audio_sample_repeat_looper_core.sv
sim/audio_sample_repeat_looper_core_test.sv
